// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

  localparam int QueueDepthDef = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX_HI,
    PH_PAIR_BS,
    PH_PAIR_U,
    PH_HEX_LO
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NO_OPEN_QUOTE  = 4'd0,
    ERR_CONTROL_CHAR   = 4'd1,
    ERR_TRUNC_ESCAPE   = 4'd2,
    ERR_BAD_ESCAPE     = 4'd3,
    ERR_TRUNC_HEX      = 4'd4,
    ERR_BAD_HEX        = 4'd5,
    ERR_MISSING_LOW    = 4'd6,
    ERR_BAD_PAIR       = 4'd7,
    ERR_STRAY_LOW      = 4'd8,
    ERR_UNTERMINATED   = 4'd9
  } err_e;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_DONE,
    CMD_ERR,
    CMD_CP
  } cmd_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    err_e       error_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cmd_e        op;
    logic [20:0] cp;
    err_e        code;
  } cmd_t;

endpackage

// ===== rtl/jsu_front.sv =====
module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t in_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  phase_e      phase_q, phase_d;
  logic [11:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;

  logic [7:0]  b;
  logic        eoi;
  logic        hex_ok;
  logic [3:0]  hex_v;
  logic [15:0] unit;
  logic        cmd_valid;

  assign b   = in_i.data_byte;
  assign eoi = in_i.end_of_input;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = b[3:0];
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_v = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      hex_v = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign unit = {acc_q, hex_v};

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    hs_d      = hs_q;
    cmd_valid = 1'b0;
    cmd_o     = '{op: CMD_BYTE, cp: '0, code: ERR_NO_OPEN_QUOTE};
    unique case (phase_q)
      PH_BODY: begin
        cmd_valid = 1'b1;
        if (eoi) begin
          cmd_o.op = CMD_ERR; cmd_o.code = ERR_UNTERMINATED; phase_d = PH_IDLE;
        end else if (b == 8'h22) begin
          cmd_o.op = CMD_DONE; phase_d = PH_IDLE;
        end else if (b < 8'h20) begin
          cmd_o.op = CMD_ERR; cmd_o.code = ERR_CONTROL_CHAR; phase_d = PH_IDLE;
        end else if (b == 8'h5C) begin
          cmd_valid = 1'b0; phase_d = PH_ESC;
        end else begin
          cmd_o.cp = {13'd0, b};
        end
      end
      PH_ESC: begin
        cmd_valid = 1'b1;
        phase_d   = PH_BODY;
        if (eoi) begin
          cmd_o.op = CMD_ERR; cmd_o.code = ERR_TRUNC_ESCAPE; phase_d = PH_IDLE;
        end else begin
          case (b)
            8'h22, 8'h5C, 8'h2F: cmd_o.cp = {13'd0, b};
            8'h62: cmd_o.cp = 21'h08;
            8'h66: cmd_o.cp = 21'h0C;
            8'h6E: cmd_o.cp = 21'h0A;
            8'h72: cmd_o.cp = 21'h0D;
            8'h74: cmd_o.cp = 21'h09;
            8'h75: begin
              cmd_valid = 1'b0; phase_d = PH_HEX_HI; acc_d = '0; cnt_d = '0;
            end
            default: begin
              cmd_o.op = CMD_ERR; cmd_o.code = ERR_BAD_ESCAPE; phase_d = PH_IDLE;
            end
          endcase
        end
      end
      PH_HEX_HI, PH_HEX_LO: begin
        if (eoi) begin
          cmd_valid = 1'b1; cmd_o.op = CMD_ERR; cmd_o.code = ERR_TRUNC_HEX;
          phase_d = PH_IDLE;
        end else if (!hex_ok) begin
          cmd_valid = 1'b1; cmd_o.op = CMD_ERR; cmd_o.code = ERR_BAD_HEX;
          phase_d = PH_IDLE;
        end else begin
          acc_d = {acc_q[7:0], hex_v};
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (phase_q == PH_HEX_HI) begin
              if (unit[15:10] == 6'b110110) begin
                hs_d = unit[9:0]; phase_d = PH_PAIR_BS;
              end else if (unit[15:10] == 6'b110111) begin
                cmd_valid = 1'b1; cmd_o.op = CMD_ERR; cmd_o.code = ERR_STRAY_LOW;
                phase_d = PH_IDLE;
              end else begin
                cmd_valid = 1'b1; cmd_o.op = CMD_CP; cmd_o.cp = {5'd0, unit};
                phase_d = PH_BODY;
              end
            end else begin
              cmd_valid = 1'b1;
              if (unit[15:10] != 6'b110111) begin
                cmd_o.op = CMD_ERR; cmd_o.code = ERR_BAD_PAIR; phase_d = PH_IDLE;
              end else begin
                cmd_o.op = CMD_CP;
                cmd_o.cp = {({1'b0, hs_q} + 11'd64), unit[9:0]};
                phase_d  = PH_BODY;
              end
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (eoi || b != 8'h5C) begin
          cmd_valid = 1'b1; cmd_o.op = CMD_ERR; cmd_o.code = ERR_MISSING_LOW;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_PAIR_U;
        end
      end
      PH_PAIR_U: begin
        if (eoi || b != 8'h75) begin
          cmd_valid = 1'b1; cmd_o.op = CMD_ERR; cmd_o.code = ERR_MISSING_LOW;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_HEX_LO; acc_d = '0; cnt_d = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (eoi) begin
          cmd_valid = 1'b1; cmd_o.op = CMD_ERR;
        end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
          phase_d = PH_IDLE;
        end else if (b == 8'h22) begin
          phase_d = PH_BODY;
        end else begin
          cmd_valid = 1'b1; cmd_o.op = CMD_ERR;
        end
      end
    endcase
  end

  assign push_o = accept_i && cmd_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      hs_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hs_q    <= hs_d;
    end
  end

endmodule

// ===== rtl/jsu_fifo.sv =====
module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output cmd_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntW'(Depth);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i) rd_q <= wrap_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

// ===== rtl/jsu_back.sv =====
module jsu_back
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, res;
  logic [1:0] nm1, trail;
  logic       last, load;
  logic [20:0] cp;

  assign cp = head_i.cp;

  always_comb begin
    nm1 = 2'd0;
    if (head_i.op == CMD_CP) begin
      if (cp <= 21'h7F)        nm1 = 2'd0;
      else if (cp <= 21'h7FF)  nm1 = 2'd1;
      else if (cp <= 21'hFFFF) nm1 = 2'd2;
      else                     nm1 = 2'd3;
    end
  end

  assign last  = idx_q == nm1;
  assign trail = nm1 - idx_q;

  always_comb begin
    res            = '{kind: KIND_BYTE, out_byte: '0, error_code: ERR_NO_OPEN_QUOTE,
                       last: last};
    unique case (head_i.op)
      CMD_BYTE: res.out_byte = cp[7:0];
      CMD_DONE: res.kind = KIND_DONE;
      CMD_ERR: begin
        res.kind       = KIND_ERR;
        res.error_code = head_i.code;
      end
      default: begin
        if (idx_q == 2'd0) begin
          case (nm1)
            2'd0:    res.out_byte = cp[7:0];
            2'd1:    res.out_byte = {3'b110, cp[10:6]};
            2'd2:    res.out_byte = {4'b1110, cp[15:12]};
            default: res.out_byte = {5'b11110, cp[20:18]};
          endcase
        end else begin
          case (trail)
            2'd0:    res.out_byte = {2'b10, cp[5:0]};
            2'd1:    res.out_byte = {2'b10, cp[11:6]};
            default: res.out_byte = {2'b10, cp[17:12]};
          endcase
        end
      end
    endcase
  end

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> head_valid_i && head_i.op == CMD_CP)
    else $error("multi-byte sequence lost its queue entry");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && head_i.op != CMD_CP |-> pop_o)
    else $error("single result entry not retired");
  a_pop_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> load) else $error("pop without transfer");

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// JSON string unescaper: takes one byte of JSON text per transfer and returns
// the decoded string as UTF-8 bytes, then a completion result, or an error
// result with its code. A parser in front takes a byte every cycle while its
// command queue (QueueDepth entries) has room, and turns each byte into at most
// one command; the back end expands a command into one to four results and
// delivers one result per cycle, while the output is not stalled, through an
// output register. An accepted byte's command is written into the queue, and
// the back end then loads its first result into the output register. Sustained
// input rate is one byte per cycle while the queue has room; a \u escape yields
// one to three UTF-8 bytes, or four for a surrogate pair, one result each.
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  logic accept, push, pop, q_valid, q_full;
  cmd_t cmd, head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (head)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

endmodule
